// ===== sv/jkve_pkg.sv =====
// Package for the JSON key/value extractor.
// Holds shared types, character and status codes and queue sizes.
// No dependencies; all other files of the block use it.
`timescale 1ns / 1ps
`default_nettype none

package jkve_pkg;

  localparam int MAX_KEY_CHARS    = 16;
  localparam int MAX_STRING_BYTES = 256;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  localparam logic [31:0] INT_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_NEG_MAG = 32'h8000_0000;

  localparam logic [2:0] ST_CHAR    = 3'd0;
  localparam logic [2:0] ST_FOUND   = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_TYPE    = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;
  localparam logic [2:0] ST_UNTERM  = 3'd5;

  localparam logic [2:0] REG_KEY_LOW  = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH = 3'd1;
  localparam logic [2:0] REG_KEY_LEN  = 3'd2;
  localparam logic [2:0] REG_KIND     = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  typedef enum logic [3:0] {
    PH_SEEK,
    PH_MATCH,
    PH_SKIP,
    PH_SKIP_ESC,
    PH_AFTER_KEY,
    PH_BEFORE_VAL,
    PH_STR,
    PH_STR_ESC,
    PH_INT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic [7:0] esc_char;
    logic [3:0] digit;
    logic       is_zero;
    logic       is_quote;
    logic       is_bslash;
    logic       is_colon;
    logic       is_ws;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_char;
    logic [31:0] int_value;
    logic [7:0]  char_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        push;
    logic        full;
  } qctl_t;

endpackage

`default_nettype wire

// ===== sv/jkve_front.sv =====
// Front end of the JSON key/value extractor: takes bytes and classifies them.
// Depends on jkve_pkg; feeds the command queue.
`timescale 1ns / 1ps
`default_nettype none

module jkve_front (
  input  wire logic          push,
  input  wire logic [7:0]    in_byte,
  output logic               full,
  input  wire logic          q_full,
  output jkve_pkg::qctl_t    q_ctl,
  output jkve_pkg::cmd_t     q_item
);

  always_comb begin
    full          = q_full;
    q_ctl.full    = q_full;
    q_ctl.push    = push && !q_full;

    q_item.byte_val  = in_byte;
    q_item.digit     = in_byte[3:0];
    q_item.is_zero   = (in_byte == jkve_pkg::CH_NUL);
    q_item.is_quote  = (in_byte == jkve_pkg::CH_QUOTE);
    q_item.is_bslash = (in_byte == jkve_pkg::CH_BSL);
    q_item.is_colon  = (in_byte == jkve_pkg::CH_COLON);
    q_item.is_ws     = (in_byte == jkve_pkg::CH_SPACE) ||
                       ((in_byte >= jkve_pkg::CH_TAB) && (in_byte <= jkve_pkg::CH_CR));
    q_item.is_digit  = (in_byte >= jkve_pkg::CH_ZERO) && (in_byte <= jkve_pkg::CH_NINE);
    q_item.is_minus  = (in_byte == jkve_pkg::CH_MINUS);
    q_item.is_sign   = (in_byte == jkve_pkg::CH_PLUS) || (in_byte == jkve_pkg::CH_MINUS);

    case (in_byte)
      jkve_pkg::CH_N: q_item.esc_char = jkve_pkg::CH_LF;
      jkve_pkg::CH_R: q_item.esc_char = jkve_pkg::CH_CR;
      jkve_pkg::CH_T: q_item.esc_char = jkve_pkg::CH_TAB;
      default:        q_item.esc_char = in_byte;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/jkve_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on jkve_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module jkve_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  jkve_pkg::qctl_t      wr_ctl,
  input  jkve_pkg::cmd_t       wr_item,
  output logic                 full,
  output logic                 empty,
  input  wire logic            rd,
  output jkve_pkg::cmd_t       rd_item
);

  jkve_pkg::cmd_t                   entries [jkve_pkg::CMD_DEPTH];
  logic [jkve_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [jkve_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [jkve_pkg::CMD_CNT_W-1:0]   count;
  logic                             do_wr;
  logic                             do_rd;

  assign full    = (count == jkve_pkg::CMD_CNT_W'(jkve_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_ctl.push && !wr_ctl.full;
  assign do_rd   = rd && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jkve_back.sv =====
// Back end of the JSON key/value extractor: scan state machine, value decoding,
// configuration registers and a two-entry result buffer. Depends on jkve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jkve_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               cmd_empty,
  input  jkve_pkg::cmd_t          cmd,
  output logic                    cmd_pop,
  input  wire logic               pop,
  output logic                    empty,
  output jkve_pkg::res_t          res
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [4:0]  key_length;
  logic        value_kind;
  logic [8:0]  out_capacity;

  jkve_pkg::phase_t phase, phase_next;
  logic [4:0]  key_pos, key_pos_next;
  logic [7:0]  chars, chars_next;
  logic [31:0] acc, acc_next;
  logic        neg, neg_next;
  logic        seen, seen_next;

  jkve_pkg::res_t res_buf [2];
  logic        res_wr_ptr;
  logic        res_rd_ptr;
  logic [1:0]  res_count;
  logic        res_pop;
  logic        space;
  logic        step;
  logic        emit;
  jkve_pkg::res_t r;

  logic [127:0] key_all;
  logic [4:0]   eff_len;
  logic [7:0]   key_ch;
  logic [7:0]   lim_m1;
  logic [35:0]  mult;
  logic [31:0]  acc_add;
  logic [31:0]  int_res;
  logic         key_done;

  assign key_all  = {key_high, key_low};
  assign eff_len  = (key_length > 5'(jkve_pkg::MAX_KEY_CHARS)) ?
                    5'(jkve_pkg::MAX_KEY_CHARS) : key_length;
  assign key_ch   = key_all[{key_pos[3:0], 3'b000} +: 8];
  assign key_done = (key_pos >= eff_len);

  always_comb begin
    if (out_capacity == 9'd0) begin
      lim_m1 = 8'd0;
    end else if ((out_capacity > 9'(jkve_pkg::MAX_STRING_BYTES)) ||
                 (out_capacity > 9'd256)) begin
      lim_m1 = (jkve_pkg::MAX_STRING_BYTES > 256) ? 8'd255 :
               8'(jkve_pkg::MAX_STRING_BYTES - 1);
    end else begin
      lim_m1 = 8'(out_capacity - 9'd1);
    end
  end

  assign mult    = ({4'd0, acc} * 36'(jkve_pkg::DECIMAL_BASE)) + {32'd0, cmd.digit};
  assign acc_add = (mult > {4'd0, jkve_pkg::INT_NEG_MAG}) ? jkve_pkg::INT_NEG_MAG : mult[31:0];
  assign int_res = neg ? (32'd0 - acc) :
                   ((acc > jkve_pkg::INT_POS_MAX) ? jkve_pkg::INT_POS_MAX : acc);

  assign res_pop = pop && !empty;
  assign space   = (res_count != 2'd2) || res_pop;
  assign step    = !cmd_empty && space;
  assign cmd_pop = step;
  assign empty   = (res_count == 2'd0);
  assign res     = res_buf[res_rd_ptr];

  always_comb begin
    phase_next   = phase;
    key_pos_next = key_pos;
    chars_next   = chars;
    acc_next     = acc;
    neg_next     = neg;
    seen_next    = seen;
    emit         = 1'b0;
    r            = '0;

    if (cmd.is_zero) begin
      r.last = 1'b1;
      unique case (phase)
        jkve_pkg::PH_DONE: begin
          r.last = 1'b0;
        end
        jkve_pkg::PH_STR, jkve_pkg::PH_STR_ESC: begin
          emit         = 1'b1;
          r.status     = jkve_pkg::ST_UNTERM;
          r.char_count = chars;
        end
        jkve_pkg::PH_BEFORE_VAL: begin
          emit     = 1'b1;
          r.status = jkve_pkg::ST_TYPE;
        end
        jkve_pkg::PH_INT: begin
          emit = 1'b1;
          if (seen) begin
            r.status    = jkve_pkg::ST_FOUND;
            r.int_value = int_res;
          end else begin
            r.status = jkve_pkg::ST_TYPE;
          end
        end
        default: begin
          emit     = 1'b1;
          r.status = jkve_pkg::ST_MISSING;
        end
      endcase
      phase_next   = jkve_pkg::PH_SEEK;
      key_pos_next = '0;
      chars_next   = '0;
      acc_next     = '0;
      neg_next     = 1'b0;
      seen_next    = 1'b0;
    end else begin
      unique case (phase)
        jkve_pkg::PH_SEEK: begin
          if (cmd.is_quote) begin
            phase_next   = jkve_pkg::PH_MATCH;
            key_pos_next = '0;
          end
        end
        jkve_pkg::PH_MATCH, jkve_pkg::PH_SKIP: begin
          if ((phase == jkve_pkg::PH_MATCH) && key_done && cmd.is_quote) begin
            phase_next = jkve_pkg::PH_AFTER_KEY;
          end else if ((phase == jkve_pkg::PH_MATCH) && !key_done &&
                       (cmd.byte_val == key_ch)) begin
            key_pos_next = key_pos + 5'd1;
          end else if (cmd.is_bslash) begin
            phase_next = jkve_pkg::PH_SKIP_ESC;
          end else if (cmd.is_quote) begin
            phase_next = jkve_pkg::PH_SEEK;
          end else begin
            phase_next = jkve_pkg::PH_SKIP;
          end
        end
        jkve_pkg::PH_SKIP_ESC: begin
          phase_next = jkve_pkg::PH_SKIP;
        end
        jkve_pkg::PH_AFTER_KEY: begin
          if (cmd.is_colon) begin
            phase_next = jkve_pkg::PH_BEFORE_VAL;
          end else if (!cmd.is_ws) begin
            if (cmd.is_quote) begin
              phase_next   = jkve_pkg::PH_MATCH;
              key_pos_next = '0;
            end else begin
              phase_next = jkve_pkg::PH_SEEK;
            end
          end
        end
        jkve_pkg::PH_BEFORE_VAL: begin
          if (!cmd.is_ws) begin
            if (!value_kind) begin
              if (cmd.is_quote) begin
                phase_next = jkve_pkg::PH_STR;
              end else begin
                phase_next = jkve_pkg::PH_DONE;
                emit       = 1'b1;
                r.status   = jkve_pkg::ST_TYPE;
                r.last     = 1'b1;
              end
            end else if (cmd.is_sign) begin
              neg_next   = cmd.is_minus;
              phase_next = jkve_pkg::PH_INT;
            end else if (cmd.is_digit) begin
              acc_next   = acc_add;
              seen_next  = 1'b1;
              phase_next = jkve_pkg::PH_INT;
            end else begin
              phase_next = jkve_pkg::PH_DONE;
              emit       = 1'b1;
              r.status   = jkve_pkg::ST_TYPE;
              r.last     = 1'b1;
            end
          end
        end
        jkve_pkg::PH_STR, jkve_pkg::PH_STR_ESC: begin
          if ((phase == jkve_pkg::PH_STR) && cmd.is_quote) begin
            phase_next   = jkve_pkg::PH_DONE;
            emit         = 1'b1;
            r.status     = jkve_pkg::ST_FOUND;
            r.char_count = chars;
            r.last       = 1'b1;
          end else if ((phase == jkve_pkg::PH_STR) && cmd.is_bslash) begin
            phase_next = jkve_pkg::PH_STR_ESC;
          end else begin
            emit = 1'b1;
            if (chars < lim_m1) begin
              phase_next   = jkve_pkg::PH_STR;
              chars_next   = chars + 8'd1;
              r.status     = jkve_pkg::ST_CHAR;
              r.out_char   = (phase == jkve_pkg::PH_STR) ? cmd.byte_val : cmd.esc_char;
              r.char_count = chars + 8'd1;
            end else begin
              phase_next   = jkve_pkg::PH_DONE;
              r.status     = jkve_pkg::ST_LONG;
              r.char_count = chars;
              r.last       = 1'b1;
            end
          end
        end
        jkve_pkg::PH_INT: begin
          if (cmd.is_digit) begin
            acc_next  = acc_add;
            seen_next = 1'b1;
          end else begin
            phase_next = jkve_pkg::PH_DONE;
            emit       = 1'b1;
            r.last     = 1'b1;
            if (seen) begin
              r.status    = jkve_pkg::ST_FOUND;
              r.int_value = int_res;
            end else begin
              r.status = jkve_pkg::ST_TYPE;
            end
          end
        end
        default: begin
          phase_next = jkve_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= '0;
      key_high     <= '0;
      key_length   <= '0;
      value_kind   <= 1'b0;
      out_capacity <= jkve_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        jkve_pkg::REG_KEY_LOW:  key_low      <= cfg_data;
        jkve_pkg::REG_KEY_HIGH: key_high     <= cfg_data;
        jkve_pkg::REG_KEY_LEN:  key_length   <= cfg_data[4:0];
        jkve_pkg::REG_KIND:     value_kind   <= cfg_data[0];
        jkve_pkg::REG_CAPACITY: out_capacity <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= jkve_pkg::PH_SEEK;
      key_pos <= '0;
      chars   <= '0;
      acc     <= '0;
      neg     <= 1'b0;
      seen    <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      key_pos <= key_pos_next;
      chars   <= chars_next;
      acc     <= acc_next;
      neg     <= neg_next;
      seen    <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= '0;
    end else begin
      if (step && emit) begin
        res_wr_ptr <= !res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= !res_rd_ptr;
      end
      if ((step && emit) && !res_pop) begin
        res_count <= res_count + 2'd1;
      end else if (!(step && emit) && res_pop) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_buf[res_wr_ptr] <= r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/json_key_value_extractor_unit.sv =====
// Top level of the streaming JSON key/value extractor.
// Depends on jkve_pkg, jkve_front, jkve_queue and jkve_back.
//
// Usage:
//   Bytes of a JSON text enter through a queue-style port: an item is taken
//   at a clock edge where push is high and full is low. Byte 0 ends the
//   document and returns the scan to its start; configuration is kept.
//   Results leave through a queue-style port: while empty is low the oldest
//   result sits on status, out_char, int_value, char_count and last, and it
//   is taken at an edge where pop is high. A document gives one result per
//   decoded string character plus one final item with last set.
//   Configuration registers are written with cfg_write, cfg_index and
//   cfg_data, in the order key low, key high, key length, value kind,
//   capacity, while no document is in flight; the user must ensure this as
//   the block does not. Throughput is one byte per cycle; when the receiver
//   stalls, the two-entry result buffer fills, the back end stops, and the
//   four-entry command queue absorbs bytes until full rises. The scan state
//   machine, including the multiply by ten of the integer accumulator, is
//   combinational; bytes wait in the command queue, results in the result
//   buffer. Synchronous reset empties both queues, clears the scan state and
//   sets the registers to their reset values (capacity 256).
`timescale 1ns / 1ps
`default_nettype none

module json_key_value_extractor_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         in_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status,
  output logic [7:0]              out_char,
  output logic signed [31:0]      int_value,
  output logic [7:0]              char_count,
  output logic                    last,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  jkve_pkg::qctl_t q_ctl;
  jkve_pkg::cmd_t  q_item;
  jkve_pkg::cmd_t  cmd;
  jkve_pkg::res_t  res;
  logic            q_full;
  logic            q_empty;
  logic            cmd_pop;

  jkve_front u_front (
    .push    (push),
    .in_byte (in_byte),
    .full    (full),
    .q_full  (q_full),
    .q_ctl   (q_ctl),
    .q_item  (q_item)
  );

  jkve_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_ctl  (q_ctl),
    .wr_item (q_item),
    .full    (q_full),
    .empty   (q_empty),
    .rd      (cmd_pop),
    .rd_item (cmd)
  );

  jkve_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_empty (q_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign status     = res.status;
  assign out_char   = res.out_char;
  assign int_value  = res.int_value;
  assign char_count = res.char_count;
  assign last       = res.last;

endmodule

`default_nettype wire

// ===== sv/jkve_checker.sv =====
// Port-level checks for json_key_value_extractor_unit, attached by bind.
// Depends on jkve_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module jkve_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic [2:0]         status,
  input wire logic [7:0]         out_char,
  input wire logic signed [31:0] int_value,
  input wire logic               last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("Queues are not empty after reset.");

  a_last_final: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (status != jkve_pkg::ST_CHAR)))
    else $error("The last flag does not match the status of the item.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status <= jkve_pkg::ST_UNTERM))
    else $error("Status code out of range.");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != jkve_pkg::ST_CHAR) |-> (out_char == 8'd0))
    else $error("A final item carries a character.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(int_value)))
    else $error("A waiting item changed before it was taken.");

endmodule

bind json_key_value_extractor_unit jkve_checker u_jkve_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming JSON key/value extractor.
// Sends directed and random JSON documents through the queue ports and checks every
// result against a predictor kept in this file; depends on jkve_pkg and the block.
`timescale 1ns / 1ps

module testbench;
  import jkve_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MODE_ITEMS   = 540;
  localparam int PHASE_DOCS   = 5;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_index;
    logic [63:0] reg_data;
    logic [7:0]  data_byte;
    bit          typed;
    res_t        want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [7:0]         in_byte;
  logic               empty;
  logic               pop;
  logic [2:0]         status;
  logic [7:0]         out_char;
  logic signed [31:0] int_value;
  logic [7:0]         char_count;
  logic               last;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  json_key_value_extractor_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop), .status(status), .out_char(out_char),
    .int_value(int_value), .char_count(char_count), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the scan state.
  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;
  logic        kind_int;
  logic [8:0]  capacity;
  phase_t      scan_at;
  logic [4:0]  key_pos;
  logic [7:0]  chars_out;
  logic [31:0] acc;
  logic        neg, seen_digit;

  res_t        awaited_outcomes[$];
  row_t        directed_rows[$];
  logic [7:0]  doc_bytes[$];
  int          body_len;
  bit          override_valid;
  res_t        override_res;
  int          send_idle, recv_idle;
  int          errors, results_checked, bytes_taken, docs_sent, settings_used;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  function automatic res_t outcome(logic [2:0] st, logic [7:0] ch, logic [31:0] val,
                                   logic [7:0] cnt, logic fin);
    res_t r;
    r.status = st;
    r.out_char = ch;
    r.int_value = val;
    r.char_count = cnt;
    r.last = fin;
    return r;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int key_span();
    return key_len > MAX_KEY_CHARS ? MAX_KEY_CHARS : int'(key_len);
  endfunction

  function automatic logic [7:0] key_byte(int pos);
    if (pos < 8) begin
      return key_lo[8*pos +: 8];
    end
    return key_hi[8*(pos-8) +: 8];
  endfunction

  function automatic void clear_scan();
    scan_at = PH_SEEK;
    key_pos = '0;
    chars_out = '0;
    acc = '0;
    neg = 1'b0;
    seen_digit = 1'b0;
  endfunction

  function automatic void skip_string(logic [7:0] c);
    if (c == CH_BSL) begin
      scan_at = PH_SKIP_ESC;
    end else if (c == CH_QUOTE) begin
      scan_at = PH_SEEK;
    end else begin
      scan_at = PH_SKIP;
    end
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [63:0] m;
    m = 64'(acc) * 64'(DECIMAL_BASE) + 64'(c - CH_ZERO);
    acc = (m > 64'(INT_NEG_MAG)) ? INT_NEG_MAG : m[31:0];
    seen_digit = 1'b1;
  endfunction

  function automatic logic [31:0] int_result();
    if (neg) begin
      return 32'd0 - acc;
    end
    return (acc > INT_POS_MAX) ? INT_POS_MAX : acc;
  endfunction

  function automatic res_t store_char(logic [7:0] ch);
    int lim;
    lim = capacity;
    if (lim == 0) lim = 1;
    if (lim > MAX_STRING_BYTES) lim = MAX_STRING_BYTES;
    if (lim > 256) lim = 256;
    scan_at = PH_STR;
    if (int'(chars_out) < lim - 1) begin
      chars_out = chars_out + 8'd1;
      return outcome(ST_CHAR, ch, 32'd0, chars_out, 1'b0);
    end
    scan_at = PH_DONE;
    return outcome(ST_LONG, 8'd0, 32'd0, chars_out, 1'b1);
  endfunction

  // Advances the scan by one byte; returns 1 when the byte yields a result.
  function automatic bit scan_byte(logic [7:0] c, output res_t r);
    bit got;
    logic [7:0] ch;
    got = 1'b0;
    r = '0;
    if (c == CH_NUL) begin
      got = 1'b1;
      case (scan_at)
        PH_DONE: got = 1'b0;
        PH_STR, PH_STR_ESC: r = outcome(ST_UNTERM, 8'd0, 32'd0, chars_out, 1'b1);
        PH_BEFORE_VAL: r = outcome(ST_TYPE, 8'd0, 32'd0, 8'd0, 1'b1);
        PH_INT: begin
          if (seen_digit) r = outcome(ST_FOUND, 8'd0, int_result(), 8'd0, 1'b1);
          else r = outcome(ST_TYPE, 8'd0, 32'd0, 8'd0, 1'b1);
        end
        default: r = outcome(ST_MISSING, 8'd0, 32'd0, 8'd0, 1'b1);
      endcase
      clear_scan();
      return got;
    end
    case (scan_at)
      PH_SEEK: begin
        if (c == CH_QUOTE) begin
          scan_at = PH_MATCH;
          key_pos = '0;
        end
      end
      PH_MATCH: begin
        if (int'(key_pos) >= key_span()) begin
          if (c == CH_QUOTE) scan_at = PH_AFTER_KEY;
          else skip_string(c);
        end else if (c == key_byte(key_pos)) begin
          key_pos = key_pos + 5'd1;
        end else begin
          skip_string(c);
        end
      end
      PH_SKIP: skip_string(c);
      PH_SKIP_ESC: scan_at = PH_SKIP;
      PH_AFTER_KEY: begin
        if (c == CH_COLON) begin
          scan_at = PH_BEFORE_VAL;
        end else if (!is_space(c)) begin
          scan_at = PH_SEEK;
          if (c == CH_QUOTE) begin
            scan_at = PH_MATCH;
            key_pos = '0;
          end
        end
      end
      PH_BEFORE_VAL: begin
        if (!is_space(c)) begin
          if (!kind_int) begin
            if (c == CH_QUOTE) begin
              scan_at = PH_STR;
            end else begin
              scan_at = PH_DONE;
              got = 1'b1;
              r = outcome(ST_TYPE, 8'd0, 32'd0, 8'd0, 1'b1);
            end
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            scan_at = PH_INT;
          end else if (is_num(c)) begin
            add_digit(c);
            scan_at = PH_INT;
          end else begin
            scan_at = PH_DONE;
            got = 1'b1;
            r = outcome(ST_TYPE, 8'd0, 32'd0, 8'd0, 1'b1);
          end
        end
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          scan_at = PH_DONE;
          got = 1'b1;
          r = outcome(ST_FOUND, 8'd0, 32'd0, chars_out, 1'b1);
        end else if (c == CH_BSL) begin
          scan_at = PH_STR_ESC;
        end else begin
          got = 1'b1;
          r = store_char(c);
        end
      end
      PH_STR_ESC: begin
        ch = c;
        if (c == CH_N) ch = CH_LF;
        else if (c == CH_R) ch = CH_CR;
        else if (c == CH_T) ch = CH_TAB;
        got = 1'b1;
        r = store_char(ch);
      end
      PH_INT: begin
        if (is_num(c)) begin
          add_digit(c);
        end else begin
          scan_at = PH_DONE;
          got = 1'b1;
          if (seen_digit) r = outcome(ST_FOUND, 8'd0, int_result(), 8'd0, 1'b1);
          else r = outcome(ST_TYPE, 8'd0, 32'd0, 8'd0, 1'b1);
        end
      end
      default: scan_at = PH_DONE;
    endcase
    return got;
  endfunction

  always @(posedge clk) begin : monitor
    res_t r;
    res_t want;
    bit got;
    if (!rst) begin
      if (pop && !empty) begin
        results_checked++;
        if (awaited_outcomes.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("testbench: unexpected result status %0d char %02h int %0d count %0d last %0b",
                     status, out_char, int_value, char_count, last);
          end
        end else begin
          want = awaited_outcomes.pop_front();
          if (status !== want.status || out_char !== want.out_char ||
              int_value !== want.int_value || char_count !== want.char_count ||
              last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("testbench: result %0d expected status %0d char %02h int %0d count %0d last %0b",
                       results_checked, want.status, want.out_char, $signed(want.int_value),
                       want.char_count, want.last);
              $display("testbench: result %0d      got status %0d char %02h int %0d count %0d last %0b",
                       results_checked, status, out_char, int_value, char_count, last);
            end
          end
        end
      end
      if (push && !full) begin
        bytes_taken++;
        got = scan_byte(in_byte, r);
        if (override_valid) awaited_outcomes.push_back(override_res);
        else if (got) awaited_outcomes.push_back(r);
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("testbench: timeout after %0d cycles", cycles);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, bit typed, res_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    override_valid = typed;
    override_res = want;
    push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Waits until the block has nothing left in flight.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      REG_KEY_LOW: key_lo = d;
      REG_KEY_HIGH: key_hi = d;
      REG_KEY_LEN: key_len = d[4:0];
      REG_KIND: kind_int = d[0];
      REG_CAPACITY: capacity = d[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic void add_row(bit cfg, logic [2:0] idx, logic [63:0] d, logic [7:0] b,
                                  bit typed, res_t want);
    row_t row;
    row.is_cfg = cfg;
    row.reg_index = idx;
    row.reg_data = d;
    row.data_byte = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    ch = 8'($urandom_range(1, 253));
    if (ch >= CH_QUOTE) ch = ch + 8'd1;
    if (ch >= CH_BSL) ch = ch + 8'd1;
    return ch;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [63:0] printable_key();
    logic [63:0] k;
    logic [7:0] ch;
    for (int i = 0; i < 8; i++) begin
      ch = 8'($urandom_range(33, 126));
      if (ch == CH_QUOTE || ch == CH_BSL) ch = ch + 8'd1;
      k[8*i +: 8] = ch;
    end
    return k;
  endfunction

  task automatic new_setting(int p);
    logic [63:0] lo, hi, junk;
    logic [4:0] len;
    logic kind_bit;
    logic [8:0] cap;
    lo = ($urandom_range(3) == 0) ? {$urandom, $urandom} : printable_key();
    hi = ($urandom_range(3) == 0) ? {$urandom, $urandom} : printable_key();
    len = ($urandom_range(4) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    kind_bit = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: cap = 9'($urandom_range(0, 3));
      1, 2: cap = 9'($urandom_range(4, 20));
      3: cap = $urandom_range(1) ? 9'd255 : 9'd256;
      4: cap = 9'($urandom_range(257, 511));
      default: cap = 9'($urandom_range(21, 254));
    endcase
    case (p)
      0: begin len = 5'd2; kind_bit = 1'b0; cap = 9'd256; end
      1: begin len = 5'd16; kind_bit = 1'b1; cap = 9'd0; end
      2: begin len = 5'd31; kind_bit = 1'b0; cap = 9'd0; end
      3: begin len = 5'd0; kind_bit = 1'b1; cap = 9'd511; end
      4: begin len = 5'd1; kind_bit = 1'b0; cap = 9'd1; end
      default: ;
    endcase
    junk = ($urandom_range(2) == 0) ? {$urandom, $urandom} : 64'd0;
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LEN, {junk[63:5], len});
    write_reg(REG_KIND, {junk[63:1], kind_bit});
    write_reg(REG_CAPACITY, {junk[63:9], cap});
    settings_used++;
  endtask

  task automatic build_doc(bit force_long);
    int pick, n, k, klen;
    bit as_text;
    logic [7:0] ch;
    doc_bytes.delete();
    klen = key_span();
    pick = force_long ? 0 : $urandom_range(99);
    if (pick >= 88) begin
      repeat ($urandom_range(1, 20)) doc_bytes.push_back(8'($urandom_range(1, 255)));
      body_len = doc_bytes.size();
      doc_bytes.push_back(CH_NUL);
      return;
    end
    if (!force_long && $urandom_range(2) == 0) begin
      doc_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(1, 4)) doc_bytes.push_back(8'($urandom_range(97, 122)));
      if ($urandom_range(1)) begin
        doc_bytes.push_back(CH_BSL);
        doc_bytes.push_back(CH_QUOTE);
      end
      doc_bytes.push_back(CH_QUOTE);
      doc_bytes.push_back(CH_COLON);
      doc_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
      doc_bytes.push_back(space_byte());
    end
    if (!force_long && $urandom_range(3) == 0) begin
      doc_bytes.push_back(CH_QUOTE);
      if ($urandom_range(1)) begin
        k = $urandom_range(0, klen);
        for (int i = 0; i < k; i++) doc_bytes.push_back(key_byte(i));
        doc_bytes.push_back(text_byte());
        doc_bytes.push_back(CH_QUOTE);
      end else begin
        for (int i = 0; i < klen; i++) doc_bytes.push_back(key_byte(i));
        doc_bytes.push_back(CH_QUOTE);
        if ($urandom_range(1)) doc_bytes.push_back(space_byte());
        doc_bytes.push_back(text_byte());
      end
    end
    doc_bytes.push_back(CH_QUOTE);
    for (int i = 0; i < klen; i++) doc_bytes.push_back(key_byte(i));
    doc_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 2)) doc_bytes.push_back(space_byte());
    doc_bytes.push_back(CH_COLON);
    repeat ($urandom_range(0, 2)) doc_bytes.push_back(space_byte());
    as_text = !kind_int;
    if (!force_long && $urandom_range(6) == 0) as_text = !as_text;
    if (!force_long && $urandom_range(19) == 0) begin
      doc_bytes.push_back(text_byte());
    end else if (as_text) begin
      doc_bytes.push_back(CH_QUOTE);
      if (force_long) n = $urandom_range(255, 262);
      else if ($urandom_range(7) == 0) n = $urandom_range(7, 40);
      else n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(5) == 0) begin
          doc_bytes.push_back(CH_BSL);
          case ($urandom_range(5))
            0: ch = CH_N;
            1: ch = CH_R;
            2: ch = CH_T;
            3: ch = CH_QUOTE;
            4: ch = CH_BSL;
            default: ch = 8'($urandom_range(1, 255));
          endcase
          doc_bytes.push_back(ch);
        end else begin
          doc_bytes.push_back(text_byte());
        end
      end
      if (force_long || $urandom_range(7) != 0) doc_bytes.push_back(CH_QUOTE);
      else if ($urandom_range(1)) doc_bytes.push_back(CH_BSL);
    end else begin
      case ($urandom_range(2))
        1: doc_bytes.push_back(CH_PLUS);
        2: doc_bytes.push_back(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) doc_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(3) != 0) begin
        ch = text_byte();
        doc_bytes.push_back(is_num(ch) ? CH_SPACE : ch);
      end
    end
    if (!force_long && pick >= 70) begin
      k = $urandom_range(1, doc_bytes.size());
      while (doc_bytes.size() > k) void'(doc_bytes.pop_back());
      body_len = doc_bytes.size();
    end else begin
      body_len = doc_bytes.size();
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(text_byte());
    end
    doc_bytes.push_back(CH_NUL);
  endtask

  initial begin : stimulus
    int mode_items;
    int phase;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_byte = 8'd0;
    cfg_write = 1'b0;
    cfg_index = REG_KEY_LOW;
    cfg_data = 64'd0;
    override_valid = 1'b0;
    override_res = '0;
    send_idle = 14;
    recv_idle = 83;
    errors = 0;
    results_checked = 0;
    bytes_taken = 0;
    docs_sent = 0;
    settings_used = 0;
    cycles = 0;
    key_lo = 64'd0;
    key_hi = 64'd0;
    key_len = 5'd0;
    kind_int = 1'b0;
    capacity = CAPACITY_RESET;
    clear_scan();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(0, REG_KEY_LOW, 64'd0, CH_NUL, 1, outcome(ST_MISSING, 8'd0, 32'd0, 8'd0, 1'b1));
    add_row(1, REG_KEY_LOW, 64'hffff_ffff_ffff_ffff, CH_NUL, 0, '0);
    add_row(1, REG_KEY_HIGH, 64'd0, CH_NUL, 0, '0);
    add_row(1, REG_KEY_LEN, 64'd0, CH_NUL, 0, '0);
    add_row(1, REG_KIND, 64'd1, CH_NUL, 0, '0);
    add_row(1, REG_CAPACITY, 64'd2, CH_NUL, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_QUOTE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_QUOTE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_COLON, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_MINUS, 0, '0);
    repeat (10) add_row(0, REG_KEY_LOW, 64'd0, CH_NINE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_NUL, 1, outcome(ST_FOUND, 8'd0, INT_NEG_MAG, 8'd0, 1'b1));
    add_row(1, REG_KIND, 64'd0, CH_NUL, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_QUOTE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_QUOTE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_COLON, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_QUOTE, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_BSL, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, CH_T, 0, '0);
    add_row(0, REG_KEY_LOW, 64'd0, "x", 1, outcome(ST_LONG, 8'd0, 32'd0, 8'd1, 1'b1));
    add_row(0, REG_KEY_LOW, 64'd0, CH_NUL, 0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (i == 0 || !directed_rows[i-1].is_cfg) settle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
      end else begin
        send_byte(directed_rows[i].data_byte, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Three idle patterns: sender mostly busy, receiver mostly busy, then no gaps.
    phase = 0;
    for (int mode = 0; mode < 3; mode++) begin
      mode_items = 0;
      while (mode_items < MODE_ITEMS) begin
        settle();
        send_idle = (mode == 0) ? 14 : (mode == 1) ? 83 : 0;
        recv_idle = (mode == 0) ? 83 : (mode == 1) ? 14 : 0;
        new_setting(phase);
        for (int d = 0; d < PHASE_DOCS && mode_items < MODE_ITEMS; d++) begin
          build_doc(phase == 0 && d == 0);
          foreach (doc_bytes[i]) send_byte(doc_bytes[i], 1'b0, '0);
          mode_items += body_len;
          docs_sent++;
        end
        phase++;
      end
    end

    settle();
    $display("testbench: %0d bytes in %0d random documents under %0d register settings",
             bytes_taken, docs_sent, settings_used);
    $display("testbench: %0d results compared, %0d mismatches, %0d cycles",
             results_checked, errors, cycles);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
